// ===== src/csl_pkg.sv =====
// Shared constants, types and elaboration-time tables for the soft limiter.
`default_nettype none

package csl_pkg;

  // Number formats.
  localparam int FRAC_BITS      = 16;
  localparam int LOG_TABLE_BITS = 8;
  localparam int LOGF           = 28;
  localparam int MANTF          = 30;
  localparam int SHARP_FRAC     = 12;

  // Port and datapath widths.
  localparam int DATA_W   = 32;
  localparam int SHARP_W  = 16;
  localparam int PROD_W   = 64;
  localparam int LOG_W    = 35;
  localparam int MANT_W   = MANTF + 2;
  localparam int TBL_N    = 1 << LOG_TABLE_BITS;
  localparam int IDX_W    = LOG_TABLE_BITS + 1;
  localparam int SLOPE_W  = 16;
  localparam int ABS_W    = 36;
  localparam int PM_W     = 40;
  localparam int U_W      = 41;
  localparam int SHCNT_W  = PM_W - LOGF;

  // Unit latencies.
  localparam int LOG_LAT    = 5;
  localparam int EXP_LAT    = 3;
  localparam int SDIV_W     = 56;
  localparam int SDIV_STEP  = 4;
  localparam int SDIV_LAT   = SDIV_W / SDIV_STEP;
  localparam int QDIV_BITS  = 33;
  localparam int QDIV_LAT   = QDIV_BITS + 1;
  localparam int NUM_W      = 96;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_GAIN  = 2'd0,
    REG_LIMIT = 2'd1,
    REG_SHARP = 2'd2,
    REG_ROUT  = 2'd3
  } cfg_idx_t;

  typedef logic [TBL_N:0][LOGF:0]     lrom_t;
  typedef logic [TBL_N:0][MANT_W-1:0] erom_t;

  // Integer square root of a 64-bit value.
  function automatic logic [63:0] isqrt64(logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v   = v_in;
    res = '0;
    bt  = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bt > v) bt = bt >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bt != 64'd0) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // log2(1 + i/2^B) in Q.28 by repeated squaring.
  function automatic lrom_t build_lrom();
    lrom_t       tab;
    logic [63:0] x;
    logic [LOGF:0] res;
    for (int i = 0; i < TBL_N; i++) begin
      x   = (64'd1 << MANTF) + (64'(i) << (MANTF - LOG_TABLE_BITS));
      res = '0;
      for (int k = 1; k <= LOGF; k++) begin
        x = (x * x) >> MANTF;
        if (x >= (64'd2 << MANTF)) begin
          x = x >> 1;
          res[LOGF-k] = 1'b1;
        end
      end
      tab[i] = res;
    end
    tab[TBL_N] = {1'b1, {LOGF{1'b0}}};
    return tab;
  endfunction

  // 2^(i/2^B) in Q2.30 as a product of successive square roots of two.
  function automatic erom_t build_erom();
    erom_t       tab;
    logic [63:0] c [LOG_TABLE_BITS+1];
    logic [63:0] acc;
    c[0] = 64'd2 << MANTF;
    for (int k = 1; k <= LOG_TABLE_BITS; k++) begin
      c[k] = isqrt64(c[k-1] << MANTF);
    end
    for (int i = 0; i < TBL_N; i++) begin
      acc = 64'd1 << MANTF;
      for (int k = 1; k <= LOG_TABLE_BITS; k++) begin
        if (((i >> (LOG_TABLE_BITS - k)) & 1) != 0) acc = (acc * c[k]) >> MANTF;
      end
      tab[i] = acc[MANT_W-1:0];
    end
    tab[TBL_N] = {2'b10, {MANTF{1'b0}}};
    return tab;
  endfunction

  localparam lrom_t LROM = build_lrom();
  localparam erom_t EROM = build_erom();

endpackage

`default_nettype wire

// ===== src/csl_log2.sv =====
// Pipelined base-2 logarithm of a 64-bit integer, Q.28 result.
`default_nettype none

module csl_log2 (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [63:0]               in_v,
  output logic                      out_valid,
  output logic [csl_pkg::LOG_W-1:0] out_log
);
  import csl_pkg::*;

  logic [LOG_LAT-1:0]        vld_r;
  logic [5:0]                m_enc;
  logic [63:0]               v1_r;
  logic [5:0]                m1_r, m2_r, m3_r, m4_r;
  logic [63:0]               norm;
  logic [LOG_TABLE_BITS-1:0] idx2_r;
  logic [SLOPE_W-1:0]        r2_r, r3_r;
  logic [LOGF:0]             lo3_r, hi3_r, lo4_r;
  logic [LOGF+SLOPE_W:0]     prod_nxt, prod4_r;
  logic [LOG_W-1:0]          log_r;

  // Position of the top set bit.
  always_comb begin
    m_enc = '0;
    for (int i = 1; i < 64; i++) begin
      if (in_v[i]) m_enc = 6'(i);
    end
  end

  assign norm     = v1_r << (6'd63 - m1_r);
  assign prod_nxt = (hi3_r > lo3_r) ?
                    (LOGF+SLOPE_W+1)'(hi3_r - lo3_r) * (LOGF+SLOPE_W+1)'(r3_r) : '0;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LOG_LAT-2:0], in_valid};
    end
  end

  // Encode, normalize, look up, scale the slope, add.
  always_ff @(posedge clk) begin
    v1_r    <= in_v;
    m1_r    <= m_enc;
    idx2_r  <= norm[62 -: LOG_TABLE_BITS];
    r2_r    <= norm[62-LOG_TABLE_BITS -: SLOPE_W];
    m2_r    <= m1_r;
    lo3_r   <= LROM[{1'b0, idx2_r}];
    hi3_r   <= LROM[IDX_W'(idx2_r) + IDX_W'(1)];
    r3_r    <= r2_r;
    m3_r    <= m2_r;
    lo4_r   <= lo3_r;
    prod4_r <= prod_nxt;
    m4_r    <= m3_r;
    log_r   <= {m4_r, {LOGF{1'b0}}} + LOG_W'(lo4_r) + LOG_W'(prod4_r[LOGF+SLOPE_W:SLOPE_W]);
  end

  assign out_valid = vld_r[LOG_LAT-1];
  assign out_log   = log_r;

endmodule

`default_nettype wire

// ===== src/csl_exp2.sv =====
// Pipelined power of two of a Q.28 fraction, Q2.30 result.
`default_nettype none

module csl_exp2 (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [csl_pkg::LOGF-1:0]   in_frac,
  output logic                       out_valid,
  output logic [csl_pkg::MANT_W-1:0] out_mant
);
  import csl_pkg::*;

  logic [EXP_LAT-1:0]          vld_r;
  logic [LOG_TABLE_BITS-1:0]   idx;
  logic [MANT_W-1:0]           lo1_r, hi1_r, lo2_r, mant_r;
  logic [SLOPE_W-1:0]          r1_r;
  logic [MANT_W+SLOPE_W-1:0]   prod_nxt, prod2_r;

  assign idx      = in_frac[LOGF-1 -: LOG_TABLE_BITS];
  assign prod_nxt = (hi1_r > lo1_r) ?
                    (MANT_W+SLOPE_W)'(hi1_r - lo1_r) * (MANT_W+SLOPE_W)'(r1_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[EXP_LAT-2:0], in_valid};
    end
  end

  // Look up, scale the slope, add.
  always_ff @(posedge clk) begin
    lo1_r   <= EROM[{1'b0, idx}];
    hi1_r   <= EROM[IDX_W'(idx) + IDX_W'(1)];
    r1_r    <= in_frac[LOGF-LOG_TABLE_BITS-1 -: SLOPE_W];
    lo2_r   <= lo1_r;
    prod2_r <= prod_nxt;
    mant_r  <= lo2_r + prod2_r[MANT_W+SLOPE_W-1:SLOPE_W];
  end

  assign out_valid = vld_r[EXP_LAT-1];
  assign out_mant  = mant_r;

endmodule

`default_nettype wire

// ===== src/csl_sdiv.sv =====
// Pipelined restoring divider by the 16-bit sharpness, four quotient bits per stage.
`default_nettype none

module csl_sdiv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [csl_pkg::SDIV_W-1:0]  in_num,
  input  logic [csl_pkg::SHARP_W-1:0] in_den,
  output logic                        out_valid,
  output logic [csl_pkg::SDIV_W-1:0]  out_quo
);
  import csl_pkg::*;

  logic [SDIV_LAT-1:0] vld_r;
  logic [SDIV_W-1:0]   num_r   [SDIV_LAT];
  logic [SDIV_W-1:0]   quo_r   [SDIV_LAT];
  logic [SHARP_W-1:0]  rem_r   [SDIV_LAT];
  logic [SHARP_W-1:0]  den_r   [SDIV_LAT];
  logic [SDIV_W-1:0]   num_nxt [SDIV_LAT];
  logic [SDIV_W-1:0]   quo_nxt [SDIV_LAT];
  logic [SHARP_W-1:0]  rem_nxt [SDIV_LAT];
  logic [SHARP_W-1:0]  den_nxt [SDIV_LAT];

  // Each stage shifts in four dividend bits and trial-subtracts the divisor.
  always_comb begin
    logic [SHARP_W:0]   trial;
    logic [SDIV_W-1:0]  num;
    logic [SDIV_W-1:0]  quo;
    logic [SHARP_W-1:0] rem;
    logic [SHARP_W-1:0] den;
    for (int s = 0; s < SDIV_LAT; s++) begin
      if (s == 0) begin
        num = in_num;
        quo = '0;
        rem = '0;
        den = in_den;
      end else begin
        num = num_r[s-1];
        quo = quo_r[s-1];
        rem = rem_r[s-1];
        den = den_r[s-1];
      end
      for (int b = 0; b < SDIV_STEP; b++) begin
        trial = {rem, num[SDIV_W-1]};
        num   = num << 1;
        if (trial >= {1'b0, den}) begin
          trial = trial - {1'b0, den};
          quo   = {quo[SDIV_W-2:0], 1'b1};
        end else begin
          quo   = {quo[SDIV_W-2:0], 1'b0};
        end
        rem = trial[SHARP_W-1:0];
      end
      num_nxt[s] = num;
      quo_nxt[s] = quo;
      rem_nxt[s] = rem;
      den_nxt[s] = den;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SDIV_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < SDIV_LAT; s++) begin
      num_r[s] <= num_nxt[s];
      quo_r[s] <= quo_nxt[s];
      rem_r[s] <= rem_nxt[s];
      den_r[s] <= den_nxt[s];
    end
  end

  assign out_valid = vld_r[SDIV_LAT-1];
  assign out_quo   = quo_r[SDIV_LAT-1];

endmodule

`default_nettype wire

// ===== src/csl_qdiv.sv =====
// Pipelined final divider: 33-bit quotient of a 96-bit numerator, with overflow flag.
`default_nettype none

module csl_qdiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [csl_pkg::NUM_W-1:0]     in_num,
  input  logic [csl_pkg::PROD_W-1:0]    in_den,
  output logic                          out_valid,
  output logic [csl_pkg::QDIV_BITS-1:0] out_quo,
  output logic                          out_ovf
);
  import csl_pkg::*;

  localparam int HI_W = NUM_W - QDIV_BITS;

  logic [QDIV_LAT-1:0]  vld_r;
  logic [PROD_W-1:0]    rem_r   [QDIV_LAT];
  logic [QDIV_BITS-1:0] low_r   [QDIV_LAT];
  logic [QDIV_BITS-1:0] quo_r   [QDIV_LAT];
  logic [PROD_W-1:0]    den_r   [QDIV_LAT];
  logic                 ovf_r   [QDIV_LAT];
  logic [PROD_W-1:0]    rem_nxt [QDIV_LAT];
  logic [QDIV_BITS-1:0] low_nxt [QDIV_LAT];
  logic [QDIV_BITS-1:0] quo_nxt [QDIV_LAT];

  // First stage checks for overflow; each later stage yields one quotient bit.
  always_comb begin
    logic [PROD_W:0] trial;
    rem_nxt[0] = PROD_W'(in_num[NUM_W-1:QDIV_BITS]);
    low_nxt[0] = in_num[QDIV_BITS-1:0];
    quo_nxt[0] = '0;
    for (int s = 1; s < QDIV_LAT; s++) begin
      trial = {rem_r[s-1], low_r[s-1][QDIV_BITS-1]};
      if (trial >= {1'b0, den_r[s-1]}) begin
        trial      = trial - {1'b0, den_r[s-1]};
        quo_nxt[s] = {quo_r[s-1][QDIV_BITS-2:0], 1'b1};
      end else begin
        quo_nxt[s] = {quo_r[s-1][QDIV_BITS-2:0], 1'b0};
      end
      rem_nxt[s] = trial[PROD_W-1:0];
      low_nxt[s] = low_r[s-1] << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QDIV_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    den_r[0] <= in_den;
    ovf_r[0] <= ({{(PROD_W-HI_W){1'b0}}, in_num[NUM_W-1:QDIV_BITS]} >= in_den);
    for (int s = 1; s < QDIV_LAT; s++) begin
      den_r[s] <= den_r[s-1];
      ovf_r[s] <= ovf_r[s-1];
    end
    for (int s = 0; s < QDIV_LAT; s++) begin
      rem_r[s] <= rem_nxt[s];
      low_r[s] <= low_nxt[s];
      quo_r[s] <= quo_nxt[s];
    end
  end

  assign out_valid = vld_r[QDIV_LAT-1];
  assign out_quo   = quo_r[QDIV_LAT-1];
  assign out_ovf   = ovf_r[QDIV_LAT-1];

endmodule

`default_nettype wire

// ===== src/cann_soft_limiter.sv =====
// Top level of the soft-limiting amplifier current model.
//
//  channel   ports                                   transfer when
//  input     start, busy, in_vin                     start && !busy
//  result    out_valid, out_current, out_saturated   out_valid (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data   cfg_valid && cfg_ready
//
// One sample enters per clock; busy stays low and a new sample may follow every cycle.
// The latency is set by the chain of log, exp and the two divider pipelines
// (the final divider alone has 34 stages: an overflow check, then one quotient bit each).
// rst_n is synchronous; it clears the valid bits and loads the register defaults.
// Results are strobed for exactly one cycle; the receiver cannot hold them off.
`default_nettype none

module cann_soft_limiter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [csl_pkg::DATA_W-1:0] in_vin,
  output logic                         out_valid,
  output logic signed [csl_pkg::DATA_W-1:0] out_current,
  output logic                         out_saturated,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [csl_pkg::DATA_W-1:0]   cfg_data
);
  import csl_pkg::*;

  localparam int TOTAL_LAT = 2 + LOG_LAT + 2 + EXP_LAT + 1 + LOG_LAT + 1 + SDIV_LAT
                           + EXP_LAT + 1 + QDIV_LAT + 1;
  localparam logic [36:0] LG_OFS  = 37'(FRAC_BITS) << LOGF;
  localparam logic [LOG_W-1:0] LOG_ONE28 = LOG_W'(LOGF) << LOGF;

  typedef struct packed {
    logic [PROD_W-1:0] n;
    logic              neg;
    logic              zero;
    logic              rz;
  } sb_n_t;

  typedef struct packed {
    sb_n_t               b;
    logic [PM_W-1:0]     pos;
    logic [SHCNT_W-1:0]  nn;
    logic                fzero;
  } sb_e1_t;

  typedef struct packed {
    sb_n_t           b;
    logic [PM_W-1:0] pos;
  } sb_l2_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic             neg;
    logic             zero;
    logic             rz;
  } sb_e2_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic rz;
  } sb_f_t;

  // Configuration registers.
  logic [DATA_W-1:0]  gain_r, limit_r, rout_r;
  logic [SHARP_W-1:0] sharp_r, sh_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= DATA_W'(65536);
      limit_r <= DATA_W'(65536);
      sharp_r <= SHARP_W'(8192);
      rout_r  <= DATA_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_GAIN:  gain_r  <= cfg_data;
        REG_LIMIT: limit_r <= cfg_data;
        REG_SHARP: sharp_r <= cfg_data[SHARP_W-1:0];
        REG_ROUT:  rout_r  <= cfg_data;
        default:   ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;
  assign sh_eff    = (sharp_r == '0) ? SHARP_W'(1) : sharp_r;

  // Stage 1: magnitude and sign.
  logic              v1_r, neg1_r;
  logic [DATA_W-1:0] a1_r;

  // Stage 2: gain product and special-case flags.
  logic  v2_r;
  sb_n_t s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    neg1_r    <= in_vin[DATA_W-1];
    a1_r      <= in_vin[DATA_W-1] ? DATA_W'(0 - in_vin) : DATA_W'(in_vin);
    s2_r.n    <= {32'b0, gain_r} * {32'b0, a1_r};
    s2_r.neg  <= neg1_r;
    s2_r.zero <= (a1_r == '0) || (gain_r == '0) || (limit_r == '0);
    s2_r.rz   <= (rout_r == '0);
  end

  // Logarithms of the product and of the limit level.
  logic             ln_v, ll_v;
  logic [LOG_W-1:0] ln_log, ll_log;
  sb_n_t            d1_r [LOG_LAT];

  csl_log2 u_log_n (
    .clk(clk), .rst_n(rst_n), .in_valid(v2_r), .in_v(s2_r.n),
    .out_valid(ln_v), .out_log(ln_log)
  );

  csl_log2 u_log_l (
    .clk(clk), .rst_n(rst_n), .in_valid(v2_r), .in_v({32'b0, limit_r}),
    .out_valid(ll_v), .out_log(ll_log)
  );

  always_ff @(posedge clk) begin
    d1_r[0] <= s2_r;
    for (int i = 1; i < LOG_LAT; i++) d1_r[i] <= d1_r[i-1];
  end

  // Stage 8: signed log ratio, split into sign and magnitude.
  logic             v8_r, lgneg8_r;
  logic [36:0]      lg;
  logic [ABS_W-1:0] absl8_r;
  sb_n_t            s8_r;

  assign lg = {2'b0, ln_log} - {2'b0, ll_log} - LG_OFS;

  // Stage 9: scale by the sharpness.
  logic                v9_r;
  logic [PM_W-1:0]     pm9_r, pos9_r;
  logic [ABS_W+SHARP_W-1:0] pm_prod;
  sb_n_t               s9_r;

  assign pm_prod = (ABS_W+SHARP_W)'(absl8_r) * (ABS_W+SHARP_W)'(sh_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else begin
      v8_r <= ln_v && ll_v;
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    lgneg8_r <= lg[36];
    absl8_r  <= lg[36] ? ABS_W'(0 - lg) : lg[ABS_W-1:0];
    s8_r     <= d1_r[LOG_LAT-1];
    pm9_r    <= pm_prod[ABS_W+SHARP_W-1:SHARP_FRAC];
    pos9_r   <= lgneg8_r ? '0 : pm_prod[ABS_W+SHARP_W-1:SHARP_FRAC];
    s9_r     <= s8_r;
  end

  // 2^-pm through the exp unit.
  logic              e1_v;
  logic [MANT_W-1:0] e1_mant;
  sb_e1_t            e1_in;
  sb_e1_t            d2_r [EXP_LAT];

  assign e1_in.b     = s9_r;
  assign e1_in.pos   = pos9_r;
  assign e1_in.nn    = pm9_r[PM_W-1:LOGF];
  assign e1_in.fzero = (pm9_r[LOGF-1:0] == '0);

  csl_exp2 u_exp_np (
    .clk(clk), .rst_n(rst_n), .in_valid(v9_r),
    .in_frac({LOGF{1'b0}} - pm9_r[LOGF-1:0]),
    .out_valid(e1_v), .out_mant(e1_mant)
  );

  always_ff @(posedge clk) begin
    d2_r[0] <= e1_in;
    for (int i = 1; i < EXP_LAT; i++) d2_r[i] <= d2_r[i-1];
  end

  // Stage 13: 1 + 2^-pm.
  logic        v13_r;
  logic [LOGF:0] np;
  logic [LOGF+1:0] t13_r;
  sb_l2_t      s13_r;
  sb_e1_t      e1_out;

  assign e1_out = d2_r[EXP_LAT-1];

  always_comb begin
    if (e1_out.nn > SHCNT_W'(LOGF + 1)) begin
      np = '0;
    end else if (e1_out.fzero) begin
      np = {1'b1, {LOGF{1'b0}}} >> e1_out.nn[5:0];
    end else begin
      np = (LOGF+1)'(e1_mant >> (e1_out.nn[5:0] + 6'd3));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v13_r <= 1'b0;
    end else begin
      v13_r <= e1_v;
    end
  end

  always_ff @(posedge clk) begin
    t13_r     <= {2'b01, {LOGF{1'b0}}} + (LOGF+2)'(np);
    s13_r.b   <= e1_out.b;
    s13_r.pos <= e1_out.pos;
  end

  // log2(1 + 2^-pm).
  logic             lt_v;
  logic [LOG_W-1:0] lt_log;
  sb_l2_t           d3_r [LOG_LAT];

  csl_log2 u_log_t (
    .clk(clk), .rst_n(rst_n), .in_valid(v13_r), .in_v(64'(t13_r)),
    .out_valid(lt_v), .out_log(lt_log)
  );

  always_ff @(posedge clk) begin
    d3_r[0] <= s13_r;
    for (int i = 1; i < LOG_LAT; i++) d3_r[i] <= d3_r[i-1];
  end

  // Stage 19: u = pos + log2(1 + 2^-pm).
  logic          v19_r;
  logic [U_W-1:0] u19_r;
  sb_n_t         s19_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v19_r <= 1'b0;
    end else begin
      v19_r <= lt_v;
    end
  end

  always_ff @(posedge clk) begin
    u19_r <= U_W'(d3_r[LOG_LAT-1].pos) + U_W'(lt_log - LOG_ONE28);
    s19_r <= d3_r[LOG_LAT-1].b;
  end

  // q = u / s.
  logic              q_v;
  logic [SDIV_W-1:0] q;
  sb_n_t             d4_r [SDIV_LAT];

  csl_sdiv u_sdiv (
    .clk(clk), .rst_n(rst_n), .in_valid(v19_r),
    .in_num({{(SDIV_W-U_W-SHARP_FRAC){1'b0}}, u19_r, {SHARP_FRAC{1'b0}}}),
    .in_den(sh_eff), .out_valid(q_v), .out_quo(q)
  );

  always_ff @(posedge clk) begin
    d4_r[0] <= s19_r;
    for (int i = 1; i < SDIV_LAT; i++) d4_r[i] <= d4_r[i-1];
  end

  // Align the numerator to the integer part of q.
  logic [SDIV_W-LOGF-1:0] qi, qj;
  logic [NUM_W-1:0]       num;
  sb_n_t                  q_sb;
  sb_e2_t                 e2_in;

  assign qi   = q[SDIV_W-1:LOGF];
  assign qj   = qi - (SDIV_W-LOGF)'(MANTF);
  assign q_sb = d4_r[SDIV_LAT-1];

  always_comb begin
    if (qi <= (SDIV_W-LOGF)'(MANTF)) begin
      num = NUM_W'(q_sb.n) << (5'(MANTF) - qi[4:0]);
    end else if (qj >= (SDIV_W-LOGF)'(64)) begin
      num = '0;
    end else begin
      num = NUM_W'(q_sb.n >> qj[5:0]);
    end
  end

  assign e2_in.num  = num;
  assign e2_in.neg  = q_sb.neg;
  assign e2_in.zero = q_sb.zero;
  assign e2_in.rz   = q_sb.rz;

  // Mantissa 2^frac(q).
  logic              e2_v;
  logic [MANT_W-1:0] e2_mant;
  sb_e2_t            d5_r [EXP_LAT];

  csl_exp2 u_exp_q (
    .clk(clk), .rst_n(rst_n), .in_valid(q_v), .in_frac(q[LOGF-1:0]),
    .out_valid(e2_v), .out_mant(e2_mant)
  );

  always_ff @(posedge clk) begin
    d5_r[0] <= e2_in;
    for (int i = 1; i < EXP_LAT; i++) d5_r[i] <= d5_r[i-1];
  end

  // Stage 37: divisor = rout * mantissa.
  logic              v37_r;
  logic [PROD_W-1:0] d37_r;
  logic [NUM_W-1:0]  num37_r;
  sb_f_t             f37_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v37_r <= 1'b0;
    end else begin
      v37_r <= e2_v;
    end
  end

  always_ff @(posedge clk) begin
    d37_r      <= {32'b0, rout_r} * PROD_W'(e2_mant);
    num37_r    <= d5_r[EXP_LAT-1].num;
    f37_r.neg  <= d5_r[EXP_LAT-1].neg;
    f37_r.zero <= d5_r[EXP_LAT-1].zero;
    f37_r.rz   <= d5_r[EXP_LAT-1].rz;
  end

  // Final quotient.
  logic                 qd_v, qd_ovf;
  logic [QDIV_BITS-1:0] qd_quo;
  sb_f_t                d6_r [QDIV_LAT];
  sb_f_t                fo;

  csl_qdiv u_qdiv (
    .clk(clk), .rst_n(rst_n), .in_valid(v37_r), .in_num(num37_r), .in_den(d37_r),
    .out_valid(qd_v), .out_quo(qd_quo), .out_ovf(qd_ovf)
  );

  always_ff @(posedge clk) begin
    d6_r[0] <= f37_r;
    for (int i = 1; i < QDIV_LAT; i++) d6_r[i] <= d6_r[i-1];
  end

  assign fo = d6_r[QDIV_LAT-1];

  // Sign, saturation and special cases into the output register.
  logic [DATA_W-1:0] cur_nxt;
  logic              sat_nxt;

  always_comb begin
    if (fo.zero) begin
      cur_nxt = '0;
      sat_nxt = 1'b0;
    end else if (fo.rz) begin
      cur_nxt = fo.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      sat_nxt = 1'b1;
    end else if (fo.neg) begin
      if (qd_ovf || (qd_quo > 33'h0_8000_0000)) begin
        cur_nxt = 32'h8000_0000;
        sat_nxt = 1'b1;
      end else begin
        cur_nxt = 32'd0 - qd_quo[DATA_W-1:0];
        sat_nxt = 1'b0;
      end
    end else begin
      if (qd_ovf || (qd_quo > 33'h0_7FFF_FFFF)) begin
        cur_nxt = 32'h7FFF_FFFF;
        sat_nxt = 1'b1;
      end else begin
        cur_nxt = qd_quo[DATA_W-1:0];
        sat_nxt = 1'b0;
      end
    end
  end

  logic              out_valid_r;
  logic [DATA_W-1:0] cur_r;
  logic              sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= qd_v;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    sat_r <= sat_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_current   = cur_r;
  assign out_saturated = sat_r;

  // A saturated result always sits at one end of the range.
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> (out_current == 32'h7FFF_FFFF ||
                                    out_current == 32'h8000_0000))
    else $error("saturated result not at range limit");

  // Every accepted sample yields a result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##TOTAL_LAT out_valid)
    else $error("result missing after pipeline latency");

  // A zero sample gives a zero, unsaturated current.
  a_zero_in: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_vin == '0 |-> ##TOTAL_LAT (out_current == '0 && !out_saturated))
    else $error("zero input gave nonzero result");

  // Reset empties the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule

`default_nettype wire
